[rtl/key_debounce_short_long_press_top_defines.svh]
// ----------------------------------------------------------------------------
// Key debounce assertion macros
// Shared concurrent assertion forms for the key debounce block.
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_SHORT_LONG_PRESS_TOP_DEFINES_SVH
`define KEY_DEBOUNCE_SHORT_LONG_PRESS_TOP_DEFINES_SVH

// same-cycle implication
`define KDSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kdsp assertion failed");

// next-cycle implication
`define KDSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kdsp assertion failed");

`endif

[rtl/kdsp_pkg.sv]
// ----------------------------------------------------------------------------
// kdsp_pkg
// Types and constants for the key debounce and press qualifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kdsp_pkg;

  localparam int NUM_KEYS   = 3;
  localparam int KEY_IDX_W  = 2;
  localparam int DEB_W      = 8;
  localparam int HOLD_W     = 16;
  localparam int EVT_W      = 2;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  typedef logic [EVT_W-1:0] evt_t;

  localparam evt_t EVT_NONE  = 2'd0;
  localparam evt_t EVT_SHORT = 2'd1;
  localparam evt_t EVT_LONG  = 2'd2;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // register index = paddr[2]
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_LONG     = 1'b1;

  localparam logic [DEB_W-1:0]  DEB_RESET  = 8'd3;
  localparam logic [HOLD_W-1:0] LONG_RESET = 16'd200;

  typedef struct packed {
    logic tick;
    logic raw;
    logic clear;
  } key_ctrl_t;

  typedef struct packed {
    logic stable_nxt;
    evt_t evt;
  } key_stat_t;

endpackage

`default_nettype wire

[rtl/kdsp_cfg.sv]
// ----------------------------------------------------------------------------
// kdsp_cfg
// APB register file holding the debounce and long-press thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kdsp_cfg
  import kdsp_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     psel,
  input  wire                     penable,
  input  wire                     pwrite,
  input  wire  [APB_AW-1:0]       paddr,
  input  wire  [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready,
  output logic [DEB_W-1:0]        debounce_count,
  output logic [HOLD_W-1:0]       long_press_count
);

  logic [DEB_W-1:0]  deb_r,  deb_nxt;
  logic [HOLD_W-1:0] long_r, long_nxt;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    deb_nxt  = deb_r;
    long_nxt = long_r;
    if (wr_en) begin
      case (paddr[2])
        REG_DEBOUNCE: deb_nxt  = pwdata[DEB_W-1:0];
        REG_LONG:     long_nxt = pwdata[HOLD_W-1:0];
        default:      deb_nxt  = deb_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r  <= DEB_RESET;
      long_r <= LONG_RESET;
    end else begin
      deb_r  <= deb_nxt;
      long_r <= long_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEBOUNCE: prdata = {{(APB_DW-DEB_W){1'b0}}, deb_r};
      REG_LONG:     prdata = {{(APB_DW-HOLD_W){1'b0}}, long_r};
      default:      prdata = '0;
    endcase
  end

  assign debounce_count   = deb_r;
  assign long_press_count = long_r;

endmodule

`default_nettype wire

[rtl/kdsp_key.sv]
// ----------------------------------------------------------------------------
// kdsp_key
// One key: debounce counter, stable level, hold counter and event latch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kdsp_key
  import kdsp_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire  [DEB_W-1:0]    debounce_count,
  input  wire  [HOLD_W-1:0]   long_press_count,
  input  wire  key_ctrl_t     ctrl,
  output key_stat_t           stat
);

  logic [DEB_W-1:0]  dc_r,     dc_nxt;
  logic              stable_r, stable_nxt;
  logic [HOLD_W-1:0] hold_r,   hold_nxt;
  logic              lf_r,     lf_nxt;
  evt_t              evt_r,    evt_nxt;

  logic [DEB_W-1:0]  dc_inc;
  logic [HOLD_W-1:0] hold_mid, hold_inc;
  logic              diff, flip, lf_mid;
  evt_t              evt_mid;

  always_comb begin
    diff     = ctrl.raw != stable_r;
    dc_inc   = dc_r + 1'b1;
    flip     = diff && (dc_inc >= debounce_count);

    dc_nxt     = dc_r;
    stable_nxt = stable_r;
    hold_nxt   = hold_r;
    lf_nxt     = lf_r;
    evt_nxt    = evt_r;

    // press restarts hold on the same tick; release without long fires short
    hold_mid = (flip && ctrl.raw) ? '0 : hold_r;
    lf_mid   = (flip && ctrl.raw) ? 1'b0 : lf_r;
    evt_mid  = (flip && !ctrl.raw && !lf_r) ? EVT_SHORT : evt_r;
    hold_inc = hold_mid + 1'b1;

    if (ctrl.tick) begin
      dc_nxt     = (diff && !flip) ? dc_inc : '0;
      stable_nxt = flip ? ctrl.raw : stable_r;
      hold_nxt   = hold_mid;
      lf_nxt     = lf_mid;
      evt_nxt    = evt_mid;
      if (stable_nxt && !lf_mid) begin
        hold_nxt = hold_inc;
        if (hold_inc >= long_press_count) begin
          lf_nxt  = 1'b1;
          evt_nxt = EVT_LONG;
        end
      end
    end else if (ctrl.clear) begin
      evt_nxt = EVT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r     <= '0;
      stable_r <= 1'b0;
      hold_r   <= '0;
      lf_r     <= 1'b0;
      evt_r    <= EVT_NONE;
    end else begin
      dc_r     <= dc_nxt;
      stable_r <= stable_nxt;
      hold_r   <= hold_nxt;
      lf_r     <= lf_nxt;
      evt_r    <= evt_nxt;
    end
  end

  assign stat.stable_nxt = stable_nxt;
  assign stat.evt        = evt_r;

endmodule

`default_nettype wire

[rtl/key_debounce_short_long_press_top.sv]
// A request is registered in s1, its result in the output register; each key updates
// in one pass through kdsp_key. Throughput: one request per cycle, held by in_stall.
// in_stall rises only when the output register is full and out_stall is high.
// Reset (rst_n low, synchronous): all key state cleared, thresholds back to 3 and 200,
// both pipeline registers empty.
// ----------------------------------------------------------------------------
// key_debounce_short_long_press_top
// Debounced key qualifier with short and long press events and APB thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "key_debounce_short_long_press_top_defines.svh"

module key_debounce_short_long_press_top
  import kdsp_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire                    in_operation,
  input  wire  [NUM_KEYS-1:0]    in_raw_levels,
  input  wire  [KEY_IDX_W-1:0]   in_key_index,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [EVT_W-1:0]       out_event_code,
  output logic [NUM_KEYS-1:0]    out_stable_levels,
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [APB_AW-1:0]      paddr,
  input  wire  [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  logic [DEB_W-1:0]     debounce_count;
  logic [HOLD_W-1:0]    long_press_count;

  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_op_r;
  logic [NUM_KEYS-1:0]  s1_raw_r;
  logic [KEY_IDX_W-1:0] s1_idx_r;

  logic                 out_valid_r, out_valid_nxt;
  evt_t                 out_evt_r;
  logic [NUM_KEYS-1:0]  out_stable_r;

  logic                 adv, proc, in_acc, idx_ok, rd_proc;
  evt_t                 rd_evt;
  logic [NUM_KEYS-1:0]  stable_pack;
  key_ctrl_t            key_ctrl [NUM_KEYS];
  key_stat_t            key_stat [NUM_KEYS];

  kdsp_cfg u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .debounce_count   (debounce_count),
    .long_press_count (long_press_count)
  );

  assign adv      = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && adv;
  assign rd_proc  = proc && (s1_op_r == OP_READ);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign idx_ok   = s1_idx_r < KEY_IDX_W'(NUM_KEYS);

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    assign key_ctrl[k].tick  = proc && (s1_op_r == OP_TICK);
    assign key_ctrl[k].raw   = s1_raw_r[k];
    assign key_ctrl[k].clear = proc && (s1_op_r == OP_READ) && (s1_idx_r == KEY_IDX_W'(k));

    kdsp_key u_key (
      .clk              (clk),
      .rst_n            (rst_n),
      .debounce_count   (debounce_count),
      .long_press_count (long_press_count),
      .ctrl             (key_ctrl[k]),
      .stat             (key_stat[k])
    );
  end

  always_comb begin
    rd_evt      = EVT_NONE;
    stable_pack = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      stable_pack[k] = key_stat[k].stable_nxt;
      if ((s1_op_r == OP_READ) && (s1_idx_r == KEY_IDX_W'(k))) begin
        rd_evt = key_stat[k].evt;
      end
    end
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (!s1_valid_r || adv) begin
      s1_valid_nxt = in_valid;
    end
    if (adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_operation;
      s1_raw_r <= in_raw_levels;
      s1_idx_r <= in_key_index;
    end
    if (proc) begin
      out_evt_r    <= idx_ok ? rd_evt : EVT_NONE;
      out_stable_r <= stable_pack;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_code    = out_evt_r;
  assign out_stable_levels = out_stable_r;

  `KDSP_ASSERT_IMP(a_stall_needs_item, in_stall, s1_valid_r)
  `KDSP_ASSERT_NXT(a_tick_no_event, proc && (s1_op_r == OP_TICK), out_evt_r == EVT_NONE)
  `KDSP_ASSERT_NXT(a_bad_idx_no_event, rd_proc && !idx_ok, out_evt_r == EVT_NONE)
  `KDSP_ASSERT_NXT(a_read_clears, rd_proc && (s1_idx_r == '0), key_stat[0].evt == EVT_NONE)

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Key debounce qualifier testbench
// Sends scan ticks and event reads over the request channel and changes both
// thresholds over APB between phases. A cycle-free predictor holds its own
// copy of the key state, and every result is checked against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import kdsp_pkg::*;

  typedef struct packed {
    evt_t                evt;
    logic [NUM_KEYS-1:0] levels;
  } key_report_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  wire                  in_stall;
  logic                 in_operation;
  logic [NUM_KEYS-1:0]  in_raw_levels;
  logic [KEY_IDX_W-1:0] in_key_index;
  wire                  out_valid;
  logic                 out_stall;
  wire  [EVT_W-1:0]     out_event_code;
  wire  [NUM_KEYS-1:0]  out_stable_levels;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  wire  [APB_DW-1:0]    prdata;
  wire                  pready;

  key_debounce_short_long_press_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_raw_levels     (in_raw_levels),
    .in_key_index      (in_key_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_code    (out_event_code),
    .out_stable_levels (out_stable_levels),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // predicted key state and thresholds
  logic [DEB_W-1:0]  deb_thr;
  logic [HOLD_W-1:0] long_thr;
  logic [DEB_W-1:0]  deb_cnt     [NUM_KEYS];
  logic              stable_q    [NUM_KEYS];
  logic [HOLD_W-1:0] press_ticks [NUM_KEYS];
  logic              long_done   [NUM_KEYS];
  evt_t              latched     [NUM_KEYS];

  key_report_t pending_reports[$];
  int          errors;
  bit          calm;
  int unsigned stall_left;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic key_report_t qualify_request(logic op, logic [NUM_KEYS-1:0] raw,
                                                  logic [KEY_IDX_W-1:0] idx);
    key_report_t rep;
    rep.evt = EVT_NONE;
    if (op == OP_TICK) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (raw[k] != stable_q[k]) begin
          deb_cnt[k] = deb_cnt[k] + 1'b1;
          if (deb_cnt[k] >= deb_thr) begin
            deb_cnt[k] = '0;
            stable_q[k] = raw[k];
            if (raw[k]) begin
              press_ticks[k] = '0;
              long_done[k] = 1'b0;
            end else if (!long_done[k]) begin
              latched[k] = EVT_SHORT;
            end
          end
        end else begin
          deb_cnt[k] = '0;
        end
        // the tick that turns a key pressed already counts toward the hold
        if (stable_q[k] && !long_done[k]) begin
          press_ticks[k] = press_ticks[k] + 1'b1;
          if (press_ticks[k] >= long_thr) begin
            long_done[k] = 1'b1;
            latched[k] = EVT_LONG;
          end
        end
      end
    end else if (idx < NUM_KEYS) begin
      rep.evt = latched[idx];
      latched[idx] = EVT_NONE;
    end
    for (int k = 0; k < NUM_KEYS; k++) rep.levels[k] = stable_q[k];
    return rep;
  endfunction

  // result side: random stall with quiet stretches
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : check_results
    key_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("result with no request pending: event_code %0d stable_levels %b",
               out_event_code, out_stable_levels);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (out_event_code !== want.evt) begin
          $error("event_code: expected %0d, actual %0d", want.evt, out_event_code);
          errors++;
        end
        if (out_stable_levels !== want.levels) begin
          $error("stable_levels: expected %b, actual %b", want.levels, out_stable_levels);
          errors++;
        end
      end
    end
  end

  task automatic send_request(logic op, logic [NUM_KEYS-1:0] raw, logic [KEY_IDX_W-1:0] idx);
    int unsigned gap;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_raw_levels <= raw;
    in_key_index  <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_reports.push_back(qualify_request(op, raw, idx));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic scan(logic [NUM_KEYS-1:0] raw);
    send_request(OP_TICK, raw, KEY_IDX_W'($urandom_range(0, 3)));
  endtask

  task automatic hold_raw(logic [NUM_KEYS-1:0] raw, int n);
    repeat (n) scan(raw);
  endtask

  task automatic read_key(int idx);
    send_request(OP_READ, NUM_KEYS'($urandom), KEY_IDX_W'(idx));
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(logic reg_sel, logic [APB_DW-1:0] value);
    drain();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == REG_DEBOUNCE) deb_thr = value[DEB_W-1:0];
    else long_thr = value[HOLD_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_directed();
    // reset thresholds: full press and release on all keys, then every index
    hold_raw(3'b111, 3);
    hold_raw(3'b000, 3);
    for (int i = 0; i < 4; i++) read_key(i);
    read_key(0);
    // zero thresholds: accepted and long on the first tick, no short on release
    apb_write(REG_DEBOUNCE, 0);
    apb_write(REG_LONG, 0);
    scan(3'b001);
    scan(3'b000);
    read_key(0);
    // a bounce restarts the count; short press then overwritten by a long one
    apb_write(REG_DEBOUNCE, 2);
    apb_write(REG_LONG, 3);
    scan(3'b010);
    scan(3'b000);
    hold_raw(3'b010, 2);
    hold_raw(3'b000, 2);
    hold_raw(3'b010, 4);
    read_key(1);
    read_key(3);
  endtask

  task automatic test_extreme_thresholds();
    apb_write(REG_DEBOUNCE, 255);
    apb_write(REG_LONG, 65535);
    // press is accepted on the 255th tick, long press stays far away
    hold_raw(3'b111, 256);
    for (int i = 0; i < NUM_KEYS; i++) read_key(i);
    apb_write(REG_DEBOUNCE, 1);
    apb_write(REG_LONG, 1);
    scan(3'b000);
    for (int i = 0; i < NUM_KEYS; i++) read_key(i);
    hold_raw(3'b101, 2);
    scan(3'b000);
    for (int i = 0; i < 4; i++) read_key(i);
  endtask

  task automatic test_random_presses();
    logic [NUM_KEYS-1:0] want;
    logic [NUM_KEYS-1:0] raw;
    int                  run_len [NUM_KEYS];
    int unsigned         r;
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        apb_write(REG_DEBOUNCE, (p == 3) ? 0 : $urandom_range(1, 5));
        apb_write(REG_LONG, $urandom_range(0, 30));
      end
      calm = (p == 2);
      want = '0;
      for (int k = 0; k < NUM_KEYS; k++) run_len[k] = $urandom_range(1, 10);
      for (int i = 0; i < 20; i++) begin
        if (i == 10) drain();
        r = $urandom_range(0, 99);
        if (r < 25) begin
          read_key($urandom_range(0, 3));
        end else begin
          // each key follows press/release runs of random length, which may be long enough to
          // debounce and sometimes to reach a long press
          for (int k = 0; k < NUM_KEYS; k++) begin
            if (run_len[k] == 0) begin
              want[k] = ~want[k];
              run_len[k] = $urandom_range(1, int'(deb_thr) + int'(long_thr) + 6);
            end else begin
              run_len[k]--;
            end
          end
          raw = want;
          if ($urandom_range(0, 99) < 8) raw[$urandom_range(0, NUM_KEYS - 1)] ^= 1'b1;
          if (r >= 95) raw = NUM_KEYS'($urandom);
          scan(raw);
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = OP_TICK;
    in_raw_levels = '0;
    in_key_index  = '0;
    out_stall     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    errors        = 0;
    calm          = 1'b0;
    stall_left    = 0;
    deb_thr       = DEB_RESET;
    long_thr      = LONG_RESET;
    for (int k = 0; k < NUM_KEYS; k++) begin
      deb_cnt[k]     = '0;
      stable_q[k]    = 1'b0;
      press_ticks[k] = '0;
      long_done[k]   = 1'b0;
      latched[k]     = EVT_NONE;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_extreme_thresholds();
    test_random_presses();

    drain();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // generous limit, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/kdsp_pkg.sv
rtl/kdsp_cfg.sv
rtl/kdsp_key.sv
rtl/key_debounce_short_long_press_top.sv
tb/testbench.sv
